// File: hw/rtl/ded_pkg.sv
// types, constants and codes shared by the digitizer event deframer
`timescale 1ns / 1ps

package ded_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int PAIRS       = 8;
    localparam int CAPACITY    = PAIRS * MAX_SAMPLES;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    localparam int WORD_W      = 32;
    localparam int HALF_W      = 16;
    localparam int SPC_W       = 13;
    localparam int PAIR_W      = 3;
    localparam int INDEX_W     = 12;
    localparam int FLAG_W      = 2;
    localparam int HPOS_W      = 4;

    localparam logic [SPC_W-1:0]  SPC_RESET   = SPC_W'(2048);
    localparam logic [WORD_W-1:0] HEADER_WORD = '1;

    // input item kind (tuser)
    localparam logic KIND_WORD  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // result item kind (tuser)
    localparam logic RESULT_PAIR    = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    // event quality flag
    localparam logic [FLAG_W-1:0] FLAG_GOOD    = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_ZERO    = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_MISSING = 2'd2;

    // position within the event header
    localparam logic [HPOS_W-1:0] HP_IDLE      = 4'd0;
    localparam logic [HPOS_W-1:0] HP_TS_LOW    = 4'd1;
    localparam logic [HPOS_W-1:0] HP_TS_HIGH   = 4'd2;
    localparam logic [HPOS_W-1:0] HP_COUNTER   = 4'd3;
    localparam logic [HPOS_W-1:0] HP_EVENT_NUM = 4'd6;
    localparam logic [HPOS_W-1:0] HP_LAST      = 4'd7;
    localparam logic [HPOS_W-1:0] HP_DATA      = 4'd8;

    // result payload, last field in the lowest bits
    typedef struct packed {
        logic [6:0]          pad;
        logic [FLAG_W-1:0]   event_flag;
        logic [WORD_W-1:0]   internal_count;
        logic [WORD_W-1:0]   event_number;
        logic [2*WORD_W-1:0] timestamp;
        logic [HALF_W-1:0]   sample_odd;
        logic [HALF_W-1:0]   sample_even;
        logic [INDEX_W-1:0]  sample_index;
        logic [PAIR_W-1:0]   channel_pair;
    } result_data_t;

    localparam int RESULT_W = $bits(result_data_t);

endpackage

// File: hw/rtl/digitizer_event_deframer_unit.sv
// top level of the digitizer event deframer
`timescale 1ns / 1ps

// Deframes a 16-channel digitizer readout stream. Each input item is one 32-bit
// word (tuser low) or an end of stream flush (tuser high). An all-ones word is a
// header; the following header words give timestamp low/high, internal counter,
// two ignored words, event number and a filler, and every later word up to the
// capacity becomes a 16-bit sample pair with its channel pair and sample index. A new
// header after an event number, or a flush, yields an event summary with a
// quality flag (missing samples over zero sample seen). One item is accepted
// every clock: the decode is a single pass from the state registers into one
// result register, so a result appears in the cycle after its item and input
// stalls only while that register holds an untaken result.
module digitizer_event_deframer_unit
    import ded_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [SPC_W-1:0]    cfg_wr_data,  // samples_per_channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,      // word
    input  logic                s_tuser,      // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RESULT_W-1:0] m_tdata,      // channel_pair, sample_index, sample_even,
                                              // sample_odd, timestamp, event_number,
                                              // internal_count, event_flag, zero pad
    output logic                m_tuser       // result_kind
);

    logic [SPC_W-1:0]    spc_reg;
    logic [HPOS_W-1:0]   header_position_reg, header_position_next;
    logic [COUNT_W-1:0]  data_word_count_reg, data_word_count_next;
    logic [WORD_W-1:0]   ts_low_reg, ts_low_next;
    logic [2*WORD_W-1:0] timestamp_reg, timestamp_next;
    logic [WORD_W-1:0]   internal_count_reg, internal_count_next;
    logic [WORD_W-1:0]   event_number_reg, event_number_next;
    logic                event_seen_reg, event_seen_next;
    logic                zero_seen_reg, zero_seen_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    result_data_t        out_data_reg, out_data_next;

    logic                accept;
    logic                has_result;
    logic [WORD_W-1:0]   count_wide;
    logic [WORD_W-1:0]   need_wide;
    logic [FLAG_W-1:0]   flag;
    logic [HALF_W-1:0]   even_half;
    logic [HALF_W-1:0]   odd_half;
    result_data_t        summary;
    result_data_t        pair;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_data_reg;

    assign count_wide = WORD_W'(data_word_count_reg);
    assign need_wide  = WORD_W'({spc_reg, 3'b000});
    assign even_half  = s_tdata[HALF_W-1:0];
    assign odd_half   = s_tdata[WORD_W-1:HALF_W];

    always_comb
    begin
        if (count_wide < need_wide)
        begin
            flag = FLAG_MISSING;
        end
        else if (zero_seen_reg)
        begin
            flag = FLAG_ZERO;
        end
        else
        begin
            flag = FLAG_GOOD;
        end
    end

    always_comb
    begin
        summary                = '0;
        summary.timestamp      = timestamp_reg;
        summary.event_number   = event_number_reg;
        summary.internal_count = internal_count_reg;
        summary.event_flag     = flag;

        pair              = '0;
        pair.channel_pair = count_wide[PAIR_W-1:0];
        pair.sample_index = count_wide[PAIR_W +: INDEX_W];
        pair.sample_even  = even_half;
        pair.sample_odd   = odd_half;
    end

    // state update and result selection for one item
    always_comb
    begin
        header_position_next = header_position_reg;
        data_word_count_next = data_word_count_reg;
        ts_low_next          = ts_low_reg;
        timestamp_next       = timestamp_reg;
        internal_count_next  = internal_count_reg;
        event_number_next    = event_number_reg;
        event_seen_next      = event_seen_reg;
        zero_seen_next       = zero_seen_reg;
        has_result           = 1'b0;
        out_kind_next        = out_kind_reg;
        out_data_next        = out_data_reg;

        if (accept)
        begin
            if (s_tuser == KIND_FLUSH)
            begin
                has_result           = 1'b1;
                out_kind_next        = RESULT_SUMMARY;
                out_data_next        = summary;
                header_position_next = HP_IDLE;
                data_word_count_next = '0;
                ts_low_next          = '0;
                timestamp_next       = '0;
                internal_count_next  = '0;
                event_number_next    = HEADER_WORD;
                event_seen_next      = 1'b0;
                zero_seen_next       = 1'b0;
            end
            else if (s_tdata == HEADER_WORD)
            begin
                if (event_seen_reg)
                begin
                    has_result           = 1'b1;
                    out_kind_next        = RESULT_SUMMARY;
                    out_data_next        = summary;
                    data_word_count_next = '0;
                    zero_seen_next       = 1'b0;
                    timestamp_next       = '0;
                end
                header_position_next = HP_TS_LOW;
            end
            else if (header_position_reg >= HP_TS_LOW && header_position_reg <= HP_LAST)
            begin
                case (header_position_reg)
                    HP_TS_LOW:    ts_low_next         = s_tdata;
                    HP_TS_HIGH:   timestamp_next      = {s_tdata, ts_low_reg};
                    HP_COUNTER:   internal_count_next = s_tdata;
                    HP_EVENT_NUM:
                    begin
                        event_number_next = s_tdata;
                        event_seen_next   = 1'b1;
                    end
                    default:      ;
                endcase
                header_position_next = header_position_reg + HPOS_W'(1);
            end
            else if (count_wide < WORD_W'(CAPACITY))
            begin
                has_result           = 1'b1;
                out_kind_next        = RESULT_PAIR;
                out_data_next        = pair;
                data_word_count_next = data_word_count_reg + COUNT_W'(1);
                if (even_half == '0 || odd_half == '0)
                begin
                    zero_seen_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (has_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg             <= SPC_RESET;
            header_position_reg <= HP_IDLE;
            data_word_count_reg <= '0;
            ts_low_reg          <= '0;
            timestamp_reg       <= '0;
            internal_count_reg  <= '0;
            event_number_reg    <= HEADER_WORD;
            event_seen_reg      <= 1'b0;
            zero_seen_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                spc_reg <= cfg_wr_data;
            end
            header_position_reg <= header_position_next;
            data_word_count_reg <= data_word_count_next;
            ts_low_reg          <= ts_low_next;
            timestamp_reg       <= timestamp_next;
            internal_count_reg  <= internal_count_next;
            event_number_reg    <= event_number_next;
            event_seen_reg      <= event_seen_next;
            zero_seen_reg       <= zero_seen_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_hpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_position_reg <= HP_DATA)
        else $error("header position out of range");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_wide <= WORD_W'(CAPACITY))
        else $error("data word count past capacity");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == KIND_FLUSH) |=>
            (header_position_reg == HP_IDLE && !event_seen_reg && !zero_seen_reg
             && data_word_count_reg == '0 && event_number_reg == HEADER_WORD))
        else $error("flush did not clear the stream state");

    a_pair_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == RESULT_PAIR) |->
            (out_data_reg.timestamp == '0 && out_data_reg.event_flag == FLAG_GOOD))
        else $error("sample pair carries summary fields");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("item taken while result register is blocked");
`endif

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the digitizer event deframer: directed and random readout streams
`timescale 1ns / 1ps

module testbench
    import ded_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic         kind;
        logic [31:0]  word;
    } readout_item_t;

    typedef struct packed {
        logic         kind;
        result_data_t data;
    } deframed_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [SPC_W-1:0]    cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;
    logic                m_tuser;

    readout_item_t    readout_words[$];
    deframed_result_t pending_results[$];

    int n_pushed = 0;
    int n_accepted = 0;
    int n_errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    // predictor state
    logic [SPC_W-1:0]    spc = SPC_RESET;
    logic [HPOS_W-1:0]   hdr_pos = HP_IDLE;
    int                  word_cnt = 0;
    logic [WORD_W-1:0]   ts_low = '0;
    logic [2*WORD_W-1:0] evt_ts = '0;
    logic [WORD_W-1:0]   int_cnt = '0;
    logic [WORD_W-1:0]   evt_num = HEADER_WORD;
    logic                evt_seen = 1'b0;
    logic                zero_seen = 1'b0;

    result_data_t     got;
    deframed_result_t want;

    digitizer_event_deframer_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic push_summary();
        deframed_result_t r;
        r = '0;
        r.kind = RESULT_SUMMARY;
        r.data.timestamp = evt_ts;
        r.data.event_number = evt_num;
        r.data.internal_count = int_cnt;
        if (word_cnt < PAIRS * int'(spc))
            r.data.event_flag = FLAG_MISSING;
        else if (zero_seen)
            r.data.event_flag = FLAG_ZERO;
        else
            r.data.event_flag = FLAG_GOOD;
        pending_results.push_back(r);
    endtask

    task automatic deframe_word(logic kind, logic [WORD_W-1:0] word);
        deframed_result_t r;
        r = '0;
        if (kind == KIND_FLUSH)
        begin
            push_summary();
            hdr_pos = HP_IDLE;
            word_cnt = 0;
            ts_low = '0;
            evt_ts = '0;
            int_cnt = '0;
            evt_num = HEADER_WORD;
            evt_seen = 1'b0;
            zero_seen = 1'b0;
            return;
        end
        if (word == HEADER_WORD)
        begin
            if (evt_seen)
            begin
                push_summary();
                word_cnt = 0;
                zero_seen = 1'b0;
                evt_ts = '0;
            end
            hdr_pos = HP_TS_LOW;
            return;
        end
        if (hdr_pos >= HP_TS_LOW && hdr_pos <= HP_LAST)
        begin
            case (hdr_pos)
                HP_TS_LOW:  ts_low = word;
                HP_TS_HIGH: evt_ts = {word, ts_low};
                HP_COUNTER: int_cnt = word;
                HP_EVENT_NUM:
                begin
                    evt_num = word;
                    evt_seen = 1'b1;
                end
                default: ;
            endcase
            hdr_pos = hdr_pos + HPOS_W'(1);
            return;
        end
        // words past capacity are dropped
        if (word_cnt >= CAPACITY)
            return;
        if (word[15:0] == '0 || word[31:16] == '0)
            zero_seen = 1'b1;
        r.kind = RESULT_PAIR;
        r.data.channel_pair = word_cnt[2:0];
        r.data.sample_index = word_cnt[14:3];
        r.data.sample_even = word[15:0];
        r.data.sample_odd = word[31:16];
        pending_results.push_back(r);
        word_cnt++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                deframe_word(s_tuser, s_tdata);
                n_accepted++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (readout_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    readout_item_t nxt;
                    nxt = readout_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.word;
                    s_tuser <= nxt.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item: kind %0d data 0x%0h", m_tuser, m_tdata);
                    n_errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    got = result_data_t'(m_tdata);
                    check_field("result_kind", want.kind, m_tuser);
                    check_field("channel_pair", want.data.channel_pair, got.channel_pair);
                    check_field("sample_index", want.data.sample_index, got.sample_index);
                    check_field("sample_even", want.data.sample_even, got.sample_even);
                    check_field("sample_odd", want.data.sample_odd, got.sample_odd);
                    check_field("timestamp", want.data.timestamp, got.timestamp);
                    check_field("event_number", want.data.event_number, got.event_number);
                    check_field("internal_count", want.data.internal_count,
                                got.internal_count);
                    check_field("event_flag", want.data.event_flag, got.event_flag);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_item(logic kind, logic [WORD_W-1:0] word);
        readout_words.push_back('{kind, word});
        n_pushed++;
    endtask

    function automatic logic [WORD_W-1:0] rand_sample_word(int zero_pct);
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        lo = HALF_W'($urandom);
        hi = HALF_W'($urandom);
        if ($urandom_range(0, 99) < zero_pct)
            lo = '0;
        if ($urandom_range(0, 99) < zero_pct)
            hi = '0;
        return {hi, lo};
    endfunction

    task automatic push_event(int n_data, int zero_pct);
        push_item(KIND_WORD, HEADER_WORD);
        repeat (7) push_item(KIND_WORD, $urandom);
        repeat (n_data) push_item(KIND_WORD, rand_sample_word(zero_pct));
    endtask

    // wait until all items are taken and all results are in, then let the block settle
    task automatic drain();
        while (n_accepted != n_pushed || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_spc(logic [SPC_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        spc = value;
    endtask

    task automatic run_random(int n_items);
        int stop_at;
        int sel;
        int need;
        int n;
        stop_at = n_pushed + n_items;
        while (n_pushed < stop_at)
        begin
            sel = $urandom_range(0, 99);
            need = PAIRS * int'(spc);
            if (sel < 70)
            begin
                case ($urandom_range(0, 3))
                    2:       n = need - $urandom_range(1, need);
                    3:       n = need + $urandom_range(1, 8);
                    default: n = need;
                endcase
                push_event(n, ($urandom_range(0, 3) == 0) ? 10 : 0);
            end
            else if (sel < 80)
            begin
                // broken header
                push_item(KIND_WORD, HEADER_WORD);
                repeat ($urandom_range(0, 6)) push_item(KIND_WORD, $urandom);
            end
            else if (sel < 88)
            begin
                repeat ($urandom_range(1, 4)) push_item(KIND_WORD, rand_sample_word(20));
            end
            else if (sel < 95)
            begin
                push_item(KIND_FLUSH, $urandom);
            end
            else
            begin
                push_item(KIND_WORD, HEADER_WORD);
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data before the first header, then a flush with no event seen
        push_item(KIND_WORD, 32'h0000_1234);
        push_item(KIND_WORD, 32'hFFFF_FFFE);
        push_item(KIND_FLUSH, 32'hFFFF_FFFF);
        // header restarted in the middle of the header words
        push_item(KIND_WORD, HEADER_WORD);
        push_item(KIND_WORD, 32'hFFFF_FFFE);
        push_item(KIND_WORD, HEADER_WORD);
        push_item(KIND_WORD, 32'h89AB_CDEF);
        push_item(KIND_WORD, 32'h0123_4567);
        push_item(KIND_WORD, 32'hFFFF_FFFE);
        push_item(KIND_WORD, 32'h0000_0000);
        push_item(KIND_WORD, 32'h7FFF_FFFF);
        push_item(KIND_WORD, 32'h8000_0000);
        push_item(KIND_WORD, 32'h0000_0000);
        push_item(KIND_WORD, 32'h0001_0001);
        push_item(KIND_WORD, HEADER_WORD);
        push_item(KIND_FLUSH, 32'h0000_0000);
        drain();

        // zero samples per channel never flags missing samples
        write_spc('0);
        push_item(KIND_WORD, 32'hABCD_0000);
        push_item(KIND_FLUSH, 32'h5555_AAAA);
        drain();

        // largest register value always flags missing samples
        write_spc('1);
        push_item(KIND_WORD, 32'h1111_2222);
        push_item(KIND_FLUSH, 32'hAAAA_5555);
        drain();

        write_spc(SPC_W'(1));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(425);

        write_spc(SPC_W'(3));
        send_idle_pct = 64;
        recv_stall_pct = 0;
        run_random(425);

        write_spc(SPC_W'(2));
        send_idle_pct = 0;
        recv_stall_pct = 64;
        run_random(425);

        write_spc(SPC_W'(4));
        send_idle_pct = 14;
        recv_stall_pct = 14;
        run_random(425);

        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
